### sv/olrb_pkg.sv
// Shared types and constants for the overwrite log ring buffer.
`timescale 1ns / 1ps

package olrb_pkg;

  // Default ring depth in bytes
  localparam int unsigned DEPTH_DEF = 1024;

  // Command codes carried by in_cmd
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_REOPEN  = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RD_WAIT = 2'd1,
    ST_HOLD    = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // execute the presented command word
    logic mem_load;  // capture registered memory data into read_data
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rd_hit;    // presented command reads a byte from the ring
  } dp_status_t;

endpackage

### sv/olrb_ctrl.sv
// Controller state machine sequencing accept, memory read and result hold.
`timescale 1ns / 1ps

module olrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  olrb_pkg::dp_status_t   status,
  output olrb_pkg::ctl_cmd_t     ctl
);

  olrb_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olrb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command outputs
  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    ctl.accept   = 1'b0;
    ctl.mem_load = 1'b0;
    unique case (state_r)
      olrb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = status.rd_hit ? olrb_pkg::ST_RD_WAIT : olrb_pkg::ST_HOLD;
        end
      end
      olrb_pkg::ST_RD_WAIT: begin
        ctl.mem_load = 1'b1;
        state_nxt    = olrb_pkg::ST_HOLD;
      end
      olrb_pkg::ST_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = olrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = olrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/olrb_dp.sv
// Datapath: byte ring memory, write/oldest/cursor pointers and result registers.
`timescale 1ns / 1ps

module olrb_dp #(
  parameter int unsigned DEPTH = olrb_pkg::DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_cmd,
  input  logic [7:0]             in_data_in,
  input  olrb_pkg::ctl_cmd_t     ctl,
  output olrb_pkg::dp_status_t   status,
  output logic [7:0]             out_read_data,
  output logic                   out_read_valid,
  output logic                   out_dropped
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q_r;

  logic [PTR_W-1:0] wr_ptr_r,  wr_ptr_nxt;
  logic [PTR_W-1:0] old_ptr_r, old_ptr_nxt;
  logic [PTR_W-1:0] cur_ptr_r, cur_ptr_nxt;

  logic [7:0]       read_data_r;
  logic             read_valid_r, read_valid_nxt;
  logic             dropped_r,    dropped_nxt;

  logic [PTR_W-1:0] wr_inc, old_inc, cur_inc;
  logic [PTR_W-1:0] rd_addr;
  logic             full, mem_we;
  olrb_pkg::cmd_t   cmd;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign cmd      = olrb_pkg::cmd_t'(in_cmd);
  assign wr_inc   = ring_next(wr_ptr_r);
  assign old_inc  = ring_next(old_ptr_r);
  assign cur_inc  = ring_next(cur_ptr_r);
  assign full     = (wr_inc == old_ptr_r);

  // Command decode and pointer update
  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    old_ptr_nxt    = old_ptr_r;
    cur_ptr_nxt    = cur_ptr_r;
    read_valid_nxt = 1'b0;
    dropped_nxt    = 1'b0;
    mem_we         = 1'b0;
    rd_addr        = cur_ptr_r;
    unique case (cmd)
      olrb_pkg::CMD_WRITE: begin
        mem_we     = 1'b1;
        wr_ptr_nxt = wr_inc;
        if (full) begin
          // drop oldest byte; drag cursor if it sat on it
          old_ptr_nxt = old_inc;
          dropped_nxt = 1'b1;
          if (cur_inc == old_inc) begin
            cur_ptr_nxt = old_inc;
          end
        end
      end
      olrb_pkg::CMD_READ: begin
        rd_addr = cur_ptr_r;
        if (cur_ptr_r != wr_ptr_r) begin
          read_valid_nxt = 1'b1;
          cur_ptr_nxt    = cur_inc;
        end
      end
      olrb_pkg::CMD_CONSUME: begin
        rd_addr = old_ptr_r;
        if (old_ptr_r != wr_ptr_r) begin
          read_valid_nxt = 1'b1;
          old_ptr_nxt    = old_inc;
        end
      end
      olrb_pkg::CMD_REOPEN: begin
        cur_ptr_nxt = old_ptr_r;
      end
      default: begin
        cur_ptr_nxt = cur_ptr_r;
      end
    endcase
  end

  assign status.rd_hit = read_valid_nxt;

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.accept && mem_we) begin
      mem[wr_ptr_r] <= in_data_in;
    end
    if (ctl.accept) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      old_ptr_r <= '0;
      cur_ptr_r <= '0;
    end else if (ctl.accept) begin
      wr_ptr_r  <= wr_ptr_nxt;
      old_ptr_r <= old_ptr_nxt;
      cur_ptr_r <= cur_ptr_nxt;
    end
  end

  // Result word registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      read_data_r  <= '0;
      read_valid_r <= read_valid_nxt;
      dropped_r    <= dropped_nxt;
    end else if (ctl.mem_load) begin
      read_data_r  <= mem_q_r;
    end
  end

  assign out_read_data  = read_data_r;
  assign out_read_valid = read_valid_r;
  assign out_dropped    = dropped_r;

endmodule

### sv/overwrite_log_ring_buffer.sv
// Top level of the overwrite-oldest byte log ring buffer.
// A write, reopen or empty read gives its result word in the cycle after
// acceptance; a read or consume that returns a byte also passes the registered
// memory read port and the RD_WAIT state before its result word is shown. The
// single-item controller takes no new command word until the result word is taken, so any output stall holds the flow.
// Reset (synchronous, rst_n low) clears the three pointers and the controller;
// ring contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps

module overwrite_log_ring_buffer #(
  parameter int unsigned DEPTH = olrb_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_read_valid,
  output logic       out_dropped
);

  olrb_pkg::ctl_cmd_t   ctl;
  olrb_pkg::dp_status_t status;

  olrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctl       (ctl)
  );

  olrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .ctl            (ctl),
    .status         (status),
    .out_read_data  (out_read_data),
    .out_read_valid (out_read_valid),
    .out_dropped    (out_dropped)
  );

endmodule

### test/overwrite_log_ring_buffer_test.sv
// Testbench for the overwrite log ring buffer: directed and random command words.
`timescale 1ns / 1ps

// Tracks the ring, its three pointers and the result words still owed by the block
class ring_log_scoreboard;
  localparam int unsigned RING_DEPTH = olrb_pkg::DEPTH_DEF;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       dropped;
  } log_word_t;

  logic [7:0]  ring [RING_DEPTH];
  int unsigned wr_ptr;
  int unsigned old_ptr;
  int unsigned cur_ptr;
  log_word_t   owed [$];
  int          fails;
  int          seen;

  function new();
    wr_ptr  = 0;
    old_ptr = 0;
    cur_ptr = 0;
    fails   = 0;
    seen    = 0;
  endfunction

  function int unsigned ring_step(int unsigned p);
    return (p + 1 == RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one accepted command word and queue the result it must produce
  function void note_word(olrb_pkg::cmd_t cmd, logic [7:0] data_in);
    log_word_t w;
    w = '{8'h00, 1'b0, 1'b0};
    case (cmd)
      olrb_pkg::CMD_WRITE: begin
        // full ring: drop oldest, drag the cursor if it sat on it
        if (ring_step(wr_ptr) == old_ptr) begin
          old_ptr = ring_step(old_ptr);
          if (ring_step(cur_ptr) == old_ptr) cur_ptr = old_ptr;
          w.dropped = 1'b1;
        end
        ring[wr_ptr] = data_in;
        wr_ptr = ring_step(wr_ptr);
      end
      olrb_pkg::CMD_READ: begin
        if (cur_ptr != wr_ptr) begin
          w.data  = ring[cur_ptr];
          w.valid = 1'b1;
          cur_ptr = ring_step(cur_ptr);
        end
      end
      olrb_pkg::CMD_CONSUME: begin
        if (old_ptr != wr_ptr) begin
          w.data  = ring[old_ptr];
          w.valid = 1'b1;
          old_ptr = ring_step(old_ptr);
        end
      end
      default: cur_ptr = old_ptr;
    endcase
    owed.push_back(w);
  endfunction

  function void report(string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  // Compare one accepted result word with the oldest one owed
  function void check_word(logic [7:0] data, logic valid, logic dropped);
    log_word_t w;
    seen++;
    if (owed.size() == 0) begin
      report($sformatf("result word %0d arrived with none owed", seen));
      return;
    end
    w = owed.pop_front();
    if (data !== w.data || valid !== w.valid || dropped !== w.dropped)
      report($sformatf(
        "result word %0d: exp data %02h valid %0b dropped %0b, got %02h %0b %0b",
        seen, w.data, w.valid, w.dropped, data, valid, dropped));
  endfunction

  function int pending();
    return owed.size();
  endfunction
endclass

module overwrite_log_ring_buffer_test;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = olrb_pkg::CMD_WRITE;
  logic [7:0] in_data_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_read_valid;
  logic       out_dropped;

  ring_log_scoreboard sb = new();
  bit                 calm = 1'b0;
  int                 cycles = 0;

  overwrite_log_ring_buffer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_read_valid(out_read_valid),
    .out_dropped   (out_dropped)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("overwrite_log_ring_buffer test failed");
      $finish;
    end
  end

  // Receiver backpressure, off during the calm stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 26);
  end

  // Monitors: accepted command words and accepted result words
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_word(olrb_pkg::cmd_t'(in_cmd), in_data_in);
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_read_data, out_read_valid, out_dropped);
  end

  // Present one command word; called and returns at a falling edge
  task automatic send_word(olrb_pkg::cmd_t cmd, logic [7:0] data_in);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_data_in <= data_in;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random words with given write/read/consume percentages, reopen for the rest
  task automatic run_mix(int count, int wr_pct, int rd_pct, int cs_pct);
    int             pick;
    olrb_pkg::cmd_t cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < wr_pct) cmd = olrb_pkg::CMD_WRITE;
      else if (pick < wr_pct + rd_pct) cmd = olrb_pkg::CMD_READ;
      else if (pick < wr_pct + rd_pct + cs_pct) cmd = olrb_pkg::CMD_CONSUME;
      else cmd = olrb_pkg::CMD_REOPEN;
      send_word(cmd, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty ring: read, consume and reopen all give zero words
    send_word(olrb_pkg::CMD_READ, 8'hFF);
    send_word(olrb_pkg::CMD_CONSUME, 8'hFF);
    send_word(olrb_pkg::CMD_REOPEN, 8'hFF);
    // Data extremes
    send_word(olrb_pkg::CMD_WRITE, 8'h00);
    send_word(olrb_pkg::CMD_WRITE, 8'hFF);
    send_word(olrb_pkg::CMD_WRITE, 8'h5A);
    send_word(olrb_pkg::CMD_READ, 8'h00);
    // Consume past the cursor, then read already-consumed bytes
    send_word(olrb_pkg::CMD_CONSUME, 8'h00);
    send_word(olrb_pkg::CMD_CONSUME, 8'h00);
    send_word(olrb_pkg::CMD_READ, 8'h00);
    send_word(olrb_pkg::CMD_READ, 8'h00);
    // Cursor at write pointer
    send_word(olrb_pkg::CMD_READ, 8'h00);
    send_word(olrb_pkg::CMD_REOPEN, 8'h00);
    send_word(olrb_pkg::CMD_READ, 8'h00);
    send_word(olrb_pkg::CMD_CONSUME, 8'h00);
    send_word(olrb_pkg::CMD_CONSUME, 8'h00);
    send_word(olrb_pkg::CMD_WRITE, 8'hA5);
    send_word(olrb_pkg::CMD_WRITE, 8'h81);
    send_word(olrb_pkg::CMD_READ, 8'h00);
    send_word(olrb_pkg::CMD_REOPEN, 8'h00);
    send_word(olrb_pkg::CMD_READ, 8'h00);

    // Fill past capacity so writes drop the oldest byte and drag the cursor
    run_mix(1150, 94, 3, 1);
    // Balanced traffic near full, first part with no idling on either side
    calm = 1'b1;
    run_mix(300, 40, 35, 15);
    calm = 1'b0;
    run_mix(150, 40, 35, 15);
    // Drain back toward empty
    run_mix(200, 15, 20, 60);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);

    if (sb.fails == 0 && sb.pending() == 0)
      $display("overwrite_log_ring_buffer test passed");
    else
      $display("overwrite_log_ring_buffer test failed");
    $finish;
  end
endmodule
